// File: rtl/core/sr2_keystream_xor_decrypt_top_macros.svh
// assertion macros shared by the keystream decryptor rtl
// no dependencies; included by files that carry concurrent checks
`ifndef SR2_KEYSTREAM_XOR_DECRYPT_TOP_MACROS_SVH
`define SR2_KEYSTREAM_XOR_DECRYPT_TOP_MACROS_SVH
`ifndef SYNTH
`define SR2_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SR2_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SR2_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SR2_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/core/sr2_kxd_pkg.sv
// types, constants and helpers for the keystream xor decryptor
// no dependencies; used by sr2_keystream_xor_decrypt_top
package sr2_kxd_pkg;

   localparam int PAD_WORDS_DEF = 128;
   localparam int LCG_STEPS     = 4;
   localparam logic [31:0] LCG_MULT = 32'd48828125;

   typedef struct packed {
      logic [31:0] cipher_word;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] plain_word;
      logic        last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LCG,
      ST_FILL,
      ST_READ,
      ST_XOR
   } state_type;

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// File: rtl/core/sr2_kxd_ram.sv
// pad memory: one write port, two read ports with registered read data
// no package dependency; instantiated by sr2_keystream_xor_decrypt_top
module sr2_kxd_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/core/sr2_keystream_xor_decrypt_top.sv
// top level of the lagged-fibonacci keystream xor decryptor
// depends on sr2_kxd_pkg, sr2_kxd_ram and the assertion macro header
// usage:
//   req channel (valid/ready) carries one cipher word and its last flag;
//   rsp channel (valid/ready) returns the plain word and a copy of the flag.
//   csr_wr_en/csr_wr_data load the 32-bit key; it is picked up when the
//   first item of a buffer is accepted.
// sequencing:
//   the first item of a buffer (after reset or after an item marked last)
//   runs the seeding sequencer: the shared lcg multiplier writes pad
//   entries 0 to 3 and the shift-xor recurrence entries 4 to 126, one pad
//   write per cycle, then the normal pad update through ST_READ and ST_XOR.
//   every other item goes through ST_READ (registered pad read) and ST_XOR;
//   a new item is taken only after the previous one has left ST_XOR.
// reset:
//   synchronous, active high; key clears to 0, pad position to the last
//   entry, seeding is armed. pad contents are not cleared.
// stall:
//   a result waits in the output register while the next item is accepted;
//   that next item holds in its final step until the output register frees.
`include "sr2_keystream_xor_decrypt_top_macros.svh"
module sr2_keystream_xor_decrypt_top #(
   parameter int PAD_WORDS = sr2_kxd_pkg::PAD_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sr2_kxd_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sr2_kxd_pkg::rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data
);
   import sr2_kxd_pkg::*;

   localparam int AW       = $clog2(PAD_WORDS);
   localparam int TAP      = PAD_WORDS / 2;
   localparam int LAST_IDX = PAD_WORDS - 1;

   state_type   state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic        seed_need_ff, seed_need_in;
   logic [31:0] key_reg_ff;
   logic [31:0] lcg_ff, lcg_in;
   logic [31:0] win_ff [LCG_STEPS];
   logic [31:0] win_in [LCG_STEPS];
   logic [31:0] word_ff, word_in;
   logic        last_ff, last_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [31:0]   rd_data_a, rd_data_b;

   logic [31:0] lcg_next;
   logic [31:0] w3_mod;
   logic [31:0] rec_word;
   logic [31:0] ks_word;
   logic        out_free;

   sr2_kxd_ram #(
      .DEPTH (PAD_WORDS),
      .WIDTH (32)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // shared lcg multiplier, operand always comes from a register
   assign lcg_next = lcg_ff * LCG_MULT + 32'd1;
   // fourth lcg word folds in the top bits of window words 1 and 3
   assign w3_mod   = {lcg_next[30:0], win_ff[1][31] ^ win_ff[3][31]};
   assign rec_word = {win_ff[0][30:0] ^ win_ff[2][30:0], win_ff[1][31] ^ win_ff[3][31]};
   assign ks_word  = rd_data_a ^ rd_data_b;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // taps stay on the current position until the item finishes
   assign rd_addr_a = AW'(pos_ff + AW'(1));
   assign rd_addr_b = AW'(pos_ff + AW'(1) + AW'(TAP));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= AW'(LAST_IDX);
         seed_need_ff <= 1'b1;
         key_reg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         seed_need_ff <= seed_need_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            key_reg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lcg_ff  <= lcg_in;
      win_ff  <= win_in;
      word_ff <= word_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      seed_need_in = seed_need_ff;
      lcg_in       = lcg_ff;
      win_in       = win_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = swap_bytes(rec_word);
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               word_in = req_data.cipher_word;
               last_in = req_data.last_word;
               lcg_in  = key_reg_ff;
               cnt_in  = '0;
               for (int i = 0; i < LCG_STEPS; i++) begin
                  win_in[i] = '0;
               end
               state_in = seed_need_ff ? ST_LCG : ST_READ;
            end
         end
         ST_LCG: begin
            lcg_in = lcg_next;
            wr_en  = 1'b1;
            for (int i = 0; i < LCG_STEPS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            if (cnt_ff == AW'(LCG_STEPS - 1)) begin
               win_in[LCG_STEPS-1] = w3_mod;
               wr_data             = swap_bytes(w3_mod);
               state_in            = ST_FILL;
            end else begin
               win_in[LCG_STEPS-1] = lcg_next;
               wr_data             = swap_bytes(lcg_next);
            end
            cnt_in = AW'(cnt_ff + AW'(1));
         end
         ST_FILL: begin
            wr_en = 1'b1;
            for (int i = 0; i < LCG_STEPS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[LCG_STEPS-1] = rec_word;
            cnt_in = AW'(cnt_ff + AW'(1));
            if (cnt_ff == AW'(LAST_IDX - 1)) begin
               pos_in       = AW'(LAST_IDX);
               seed_need_in = 1'b0;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_XOR;
         end
         ST_XOR: begin
            wr_addr = pos_ff;
            wr_data = ks_word;
            if (out_free) begin
               wr_en               = 1'b1;
               rsp_in.plain_word   = word_ff ^ ks_word;
               rsp_in.last_out     = last_ff;
               rsp_valid_in        = 1'b1;
               pos_in              = AW'(pos_ff + AW'(1));
               if (last_ff) begin
                  seed_need_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SR2_ASSERT_IMP(a_lcg_count, clock, reset, state_ff == ST_LCG, cnt_ff < AW'(LCG_STEPS), "lcg step count out of range")
   `SR2_ASSERT_NXT(a_seed_done, clock, reset, state_ff == ST_FILL && state_in == ST_READ, pos_ff == AW'(LAST_IDX) && !seed_need_ff, "seeding did not leave position at last entry")
   `SR2_ASSERT_NXT(a_result_out, clock, reset, state_ff == ST_XOR && out_free, rsp_valid_ff && state_ff == ST_IDLE, "finished item did not reach output register")
   `SR2_ASSERT_IMP(a_seed_write, clock, reset, state_ff == ST_LCG || state_ff == ST_FILL, wr_en && wr_addr != AW'(LAST_IDX), "seeding must write below the last pad entry")

endmodule
